### hw/rtl/rtmg_pkg.sv
// Package for the rotating texture matrix generator: sizes, register indexes and sine table builder.
package rtmg_pkg;

    // Quarter-wave sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_QSIZE      = 1 << SINE_TABLE_BITS;
    localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;

    // Unsigned 64-bit word used by the table builder
    typedef longint unsigned u64_t;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Phase offsets: rounding to the table grid and a quarter turn for cosine
    localparam logic [31:0] ROM_ROUND    = 32'd1 << (29 - SINE_TABLE_BITS);
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_RATE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_U    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_V    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_U    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_V    = 3'd4;

    // Q16.16 one
    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

    // Q1.15 sine magnitudes, entry SINE_QSIZE holds exactly 1.0
    typedef logic [SINE_QSIZE:0][15:0] sine_rom_t;

    // Shift-and-subtract quotient for the small Taylor divisors
    function automatic u64_t div_small(input u64_t num, input u64_t den);
        u64_t quo;
        u64_t rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // Builds the table with a truncated Taylor series in Q2.30, rounded to Q1.15
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned dv;
        longint          sum;
        rom = '0;
        for (int i = 0; i <= SINE_QSIZE; i++) begin
            x    = (HALF_PI_Q30 * u64_t'(i)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                dv   = u64_t'((2 * k) * (2 * k + 1));
                term = div_small((term * x2) >> 30, dv);
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            rom[i] = 16'((u64_t'(sum) + 64'd16384) >> 15);
        end
        return rom;
    endfunction

endpackage

### hw/rtl/rotating_texture_matrix_generator_unit.sv
// Rotating texture matrix generator: microcoded sequencer over one shared multiplier.
//
// Usage:
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while the
//   block is idle: 0 phase_rate, 1 scale_u, 2 scale_v, 3 pivot_u, 4 pivot_v.
//   Writes to other indexes are dropped.
//   Input channel (s_valid / s_ready / s_time_ms): one transaction per frame with
//   the current millisecond time. The phase advances by phase_rate times the
//   elapsed time, and a 2x3 rotate-about-pivot-then-scale matrix is produced.
//   Result channel (m_valid / m_ready / m_row*): one transaction per input, six
//   signed Q16.16 saturated entries; the constant third column is not sent.
//   A new transaction is taken once the 21-step microprogram returns to its idle
//   step, so each item is finished before the next is taken. The multiply-accumulate
//   program runs all products through the single 33x33 multiplier.
//   The result sits in an output register; the sequencer takes and computes the
//   next item while it waits and only stalls on its last step if the previous
//   result has still not been taken.
//   Reset (aresetn low, synchronous): registers return to their defaults
//   (unit scale, zero rate, zero pivot), time and phase clear, no result pending.
module rotating_texture_matrix_generator_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [rtmg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rtmg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [31:0]                          s_time_ms,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [31:0]                   m_row0_a,
    output logic signed [31:0]                   m_row0_b,
    output logic signed [31:0]                   m_row0_offset,
    output logic signed [31:0]                   m_row1_a,
    output logic signed [31:0]                   m_row1_b,
    output logic signed [31:0]                   m_row1_offset
);
    import rtmg_pkg::*;

    // Sine table, read with registered data
    localparam sine_rom_t SINE_ROM = build_sine_rom();

    localparam logic signed [65:0] RND_15  = 66'sd16384;
    localparam logic signed [65:0] RND_16  = 66'sd32768;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
    localparam logic signed [32:0] ONE_Q15 = 33'sd32768;

    // Microprogram addresses
    typedef enum logic [4:0] {
        ST_IDLE, ST_RATE_MUL, ST_PHASE_ADD, ST_SIN_RD, ST_COS_RD, ST_COS_LD,
        ST_MUL_CPU, ST_MUL_SPV, ST_MUL_PU, ST_MUL_SPU, ST_MUL_CPV, ST_MUL_PV,
        ST_MUL_SUC, ST_MUL_SUS, ST_MUL_SUT0, ST_MUL_SVS, ST_MUL_SVC, ST_MUL_SVT1,
        ST_ACC_SVT1, ST_WB_R1O, ST_OUT
    } step_t;

    typedef enum logic [1:0] {COND_NEXT, COND_WAIT_IN, COND_WAIT_OUT} cond_t;
    typedef enum logic [2:0] {A_RATE, A_SU, A_SV, A_PU, A_PV, A_T0, A_T1} a_sel_t;
    typedef enum logic [1:0] {B_DELTA, B_SIN, B_COS, B_ONE} b_sel_t;
    typedef enum logic [2:0] {ACC_NOP, ACC_LOAD, ACC_NEG, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [2:0] {
        DST_NONE, DST_T0, DST_T1, DST_R0A, DST_R0B, DST_R0O, DST_R1A, DST_R1B
    } dst_t;

    // One control word per step; the last writeback (row1 offset) has its own flag
    typedef struct packed {
        cond_t   cond;
        step_t   target;
        logic    in_take;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        logic    ph_upd;
        logic    rom_rd;
        logic    rom_cos;
        logic    ld_sin;
        logic    ld_cos;
        acc_op_t acc_op;
        dst_t    wb_dst;
        logic    wb_r1o;
        logic    wb_rnd16;
        logic    out_load;
    } ucw_t;

    localparam ucw_t UCW_NOP = '{
        cond: COND_NEXT, target: ST_IDLE, in_take: 1'b0, a_sel: A_RATE, b_sel: B_DELTA,
        ph_upd: 1'b0, rom_rd: 1'b0, rom_cos: 1'b0, ld_sin: 1'b0, ld_cos: 1'b0,
        acc_op: ACC_NOP, wb_dst: DST_NONE, wb_r1o: 1'b0, wb_rnd16: 1'b0, out_load: 1'b0
    };

    // Microcode ROM. Each word multiplies into prod, folds the previous product
    // into acc, and rounds/saturates the previous acc into a destination.
    function automatic ucw_t ucode(input step_t st);
        ucw_t w;
        w = UCW_NOP;
        unique case (st)
            ST_IDLE:      begin w.cond = COND_WAIT_IN; w.in_take = 1'b1; end
            ST_RATE_MUL:  begin w.a_sel = A_RATE; w.b_sel = B_DELTA; end
            ST_PHASE_ADD: begin w.ph_upd = 1'b1; end
            ST_SIN_RD:    begin w.rom_rd = 1'b1; end
            ST_COS_RD:    begin w.rom_rd = 1'b1; w.rom_cos = 1'b1; w.ld_sin = 1'b1; end
            ST_COS_LD:    begin w.ld_cos = 1'b1; end
            // T0 = c*pu - s*pv - pu
            ST_MUL_CPU:   begin w.a_sel = A_PU; w.b_sel = B_COS; end
            ST_MUL_SPV:   begin w.a_sel = A_PV; w.b_sel = B_SIN; w.acc_op = ACC_LOAD; end
            ST_MUL_PU:    begin w.a_sel = A_PU; w.b_sel = B_ONE; w.acc_op = ACC_SUB; end
            // T1 = s*pu + c*pv - pv
            ST_MUL_SPU:   begin w.a_sel = A_PU; w.b_sel = B_SIN; w.acc_op = ACC_SUB; end
            ST_MUL_CPV:   begin
                w.a_sel = A_PV; w.b_sel = B_COS; w.acc_op = ACC_LOAD; w.wb_dst = DST_T0;
            end
            ST_MUL_PV:    begin w.a_sel = A_PV; w.b_sel = B_ONE; w.acc_op = ACC_ADD; end
            // row 0
            ST_MUL_SUC:   begin w.a_sel = A_SU; w.b_sel = B_COS; w.acc_op = ACC_SUB; end
            ST_MUL_SUS:   begin
                w.a_sel = A_SU; w.b_sel = B_SIN; w.acc_op = ACC_LOAD; w.wb_dst = DST_T1;
            end
            ST_MUL_SUT0:  begin
                w.a_sel = A_SU; w.b_sel = B_ONE; w.acc_op = ACC_NEG; w.wb_dst = DST_R0A;
            end
            // row 1
            ST_MUL_SVS:   begin
                w.a_sel = A_SV; w.b_sel = B_SIN; w.acc_op = ACC_NEG; w.wb_dst = DST_R0B;
            end
            ST_MUL_SVC:   begin
                w.a_sel = A_SV; w.b_sel = B_COS; w.acc_op = ACC_LOAD; w.wb_dst = DST_R0O;
                w.wb_rnd16 = 1'b1;
            end
            ST_MUL_SVT1:  begin
                w.a_sel = A_SV; w.b_sel = B_ONE; w.acc_op = ACC_LOAD; w.wb_dst = DST_R1A;
            end
            ST_ACC_SVT1:  begin w.acc_op = ACC_NEG; w.wb_dst = DST_R1B; end
            ST_WB_R1O:    begin w.wb_r1o = 1'b1; w.wb_rnd16 = 1'b1; end
            ST_OUT:       begin w.cond = COND_WAIT_OUT; w.target = ST_IDLE; w.out_load = 1'b1; end
            default:      begin w.cond = COND_WAIT_OUT; w.target = ST_IDLE; end
        endcase
        return w;
    endfunction

    // Round half up by 2^15 or 2^16, then saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [65:0] v,
                                                     input logic rnd16);
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        sum = v + (rnd16 ? RND_16 : RND_15);
        sh  = rnd16 ? (sum >>> 16) : (sum >>> 15);
        if (sh > SAT_MAX) begin
            return SAT_MAX[31:0];
        end else if (sh < SAT_MIN) begin
            return SAT_MIN[31:0];
        end
        return sh[31:0];
    endfunction

    // Control state
    step_t              step_reg, step_next;
    logic               m_valid_reg;
    logic signed [31:0] phase_rate_reg, scale_u_reg, scale_v_reg, pivot_u_reg, pivot_v_reg;
    logic [31:0]        prev_time_reg;
    logic [31:0]        phase_reg;

    // Datapath
    logic [31:0]              delta_reg;
    logic signed [65:0]       prod_reg;
    logic signed [65:0]       acc_reg;
    logic [15:0]              rom_data_reg;
    logic                     rom_neg_reg;
    logic signed [16:0]       sin_reg, cos_reg;
    logic signed [31:0]       t0_reg, t1_reg;
    logic signed [31:0]       r0a_reg, r0b_reg, r0o_reg, r1a_reg, r1b_reg, r1o_reg;
    logic signed [31:0]       m_row0_a_reg, m_row0_b_reg, m_row0_offset_reg;
    logic signed [31:0]       m_row1_a_reg, m_row1_b_reg, m_row1_offset_reg;

    ucw_t                     ucw;
    logic                     in_fire;
    logic                     out_free;
    logic                     out_fire;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [31:0]       wb_value;
    logic [31:0]              rom_phase;
    logic [1:0]               rom_quad;
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    logic [SINE_ADDR_W-1:0]   rom_addr;

    assign ucw      = ucode(step_reg);
    assign s_ready  = ucw.in_take;
    assign in_fire  = s_valid && ucw.in_take;
    assign out_free = !m_valid_reg || m_ready;
    assign out_fire = ucw.out_load && out_free;

    // Sequencer: advance, or hold on a wait condition
    always_comb begin
        step_next = step_t'(step_reg + 5'd1);
        unique case (ucw.cond)
            COND_WAIT_IN:  if (!s_valid) step_next = step_reg;
            COND_WAIT_OUT: step_next = out_free ? ucw.target : step_reg;
            default:       ;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        unique case (ucw.a_sel)
            A_RATE:  mul_a = 33'(phase_rate_reg);
            A_SU:    mul_a = 33'(scale_u_reg);
            A_SV:    mul_a = 33'(scale_v_reg);
            A_PU:    mul_a = 33'(pivot_u_reg);
            A_PV:    mul_a = 33'(pivot_v_reg);
            A_T0:    mul_a = 33'(t0_reg);
            A_T1:    mul_a = 33'(t1_reg);
            default: mul_a = '0;
        endcase
        unique case (ucw.b_sel)
            B_DELTA: mul_b = $signed({1'b0, delta_reg});
            B_SIN:   mul_b = 33'(sin_reg);
            B_COS:   mul_b = 33'(cos_reg);
            default: mul_b = ONE_Q15;
        endcase
        // scale times T uses the T operand in place of the Q15 one
        if (step_reg == ST_MUL_SUT0) begin
            mul_b = 33'(t0_reg);
        end else if (step_reg == ST_MUL_SVT1) begin
            mul_b = 33'(t1_reg);
        end
    end

    // Quarter-wave table addressing
    always_comb begin
        rom_phase = phase_reg + (ucw.rom_cos ? QUARTER_TURN : 32'd0) + ROM_ROUND;
        rom_quad  = rom_phase[31:30];
        rom_idx   = rom_phase[29 -: SINE_TABLE_BITS];
        rom_addr  = rom_quad[0] ? (SINE_ADDR_W'(SINE_QSIZE) - {1'b0, rom_idx})
                                : {1'b0, rom_idx};
    end

    assign wb_value = round_sat(acc_reg, ucw.wb_rnd16);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            phase_rate_reg <= '0;
            scale_u_reg    <= SCALE_RESET;
            scale_v_reg    <= SCALE_RESET;
            pivot_u_reg    <= '0;
            pivot_v_reg    <= '0;
            prev_time_reg  <= '0;
            phase_reg      <= '0;
        end else begin
            step_reg <= step_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PHASE_RATE: phase_rate_reg <= $signed(cfg_wdata);
                    REG_SCALE_U:    scale_u_reg    <= $signed(cfg_wdata);
                    REG_SCALE_V:    scale_v_reg    <= $signed(cfg_wdata);
                    REG_PIVOT_U:    pivot_u_reg    <= $signed(cfg_wdata);
                    REG_PIVOT_V:    pivot_v_reg    <= $signed(cfg_wdata);
                    default:        ;
                endcase
            end
            if (in_fire) begin
                prev_time_reg <= s_time_ms;
            end
            if (ucw.ph_upd) begin
                phase_reg <= phase_reg + prod_reg[31:0];
            end
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            delta_reg <= s_time_ms - prev_time_reg;
        end
        prod_reg <= mul_a * mul_b;

        // accumulator
        case (ucw.acc_op)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_NEG:  acc_reg <= -prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            ACC_SUB:  acc_reg <= acc_reg - prod_reg;
            default:  ;
        endcase

        // sine table read and sign fix-up
        if (ucw.rom_rd) begin
            rom_data_reg <= SINE_ROM[rom_addr];
            rom_neg_reg  <= rom_quad[1];
        end
        if (ucw.ld_sin) begin
            sin_reg <= rom_neg_reg ? -$signed({1'b0, rom_data_reg}) : $signed({1'b0, rom_data_reg});
        end
        if (ucw.ld_cos) begin
            cos_reg <= rom_neg_reg ? -$signed({1'b0, rom_data_reg}) : $signed({1'b0, rom_data_reg});
        end

        // writeback of rounded, saturated accumulator
        unique case (ucw.wb_dst)
            DST_T0:  t0_reg  <= wb_value;
            DST_T1:  t1_reg  <= wb_value;
            DST_R0A: r0a_reg <= wb_value;
            DST_R0B: r0b_reg <= wb_value;
            DST_R0O: r0o_reg <= wb_value;
            DST_R1A: r1a_reg <= wb_value;
            DST_R1B: r1b_reg <= wb_value;
            default: ;
        endcase
        if (ucw.wb_r1o) begin
            r1o_reg <= wb_value;
        end

        // output register
        if (out_fire) begin
            m_row0_a_reg      <= r0a_reg;
            m_row0_b_reg      <= r0b_reg;
            m_row0_offset_reg <= r0o_reg;
            m_row1_a_reg      <= r1a_reg;
            m_row1_b_reg      <= r1b_reg;
            m_row1_offset_reg <= r1o_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_row0_a      = m_row0_a_reg;
    assign m_row0_b      = m_row0_b_reg;
    assign m_row0_offset = m_row0_offset_reg;
    assign m_row1_a      = m_row1_a_reg;
    assign m_row1_b      = m_row1_b_reg;
    assign m_row1_offset = m_row1_offset_reg;

endmodule

### hw/rtl/rtmg_checker.sv
// Port-level checker for the rotating texture matrix generator, bound to the top level.
module rtmg_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [31:0]                       s_time_ms,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [31:0]                m_row0_a,
    input logic signed [31:0]                m_row0_b,
    input logic signed [31:0]                m_row0_offset,
    input logic signed [31:0]                m_row1_a,
    input logic signed [31:0]                m_row1_b,
    input logic signed [31:0]                m_row1_offset
);

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row0_a) && $stable(m_row0_b) &&
        $stable(m_row0_offset) && $stable(m_row1_a) && $stable(m_row1_b) &&
        $stable(m_row1_offset))
        else $error("stalled result dropped or changed");

    // A waiting input transaction stays offered with the same time stamp
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_time_ms))
        else $error("pending input dropped or changed");

    // The sequencer takes one transaction at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back-to-back cycles");

    // A result never appears the cycle after its input was taken
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind rotating_texture_matrix_generator_unit rtmg_checker u_rtmg_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rotating texture matrix generator unit.
module tb;
    import rtmg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 30;   // extra wait after the last result is checked
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 102;
    localparam int RANDOM_PHASES  = 8;

    localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    // Matrix entry positions
    localparam int FLD_ROW0_A   = 0;
    localparam int FLD_ROW0_B   = 1;
    localparam int FLD_ROW0_OFS = 2;
    localparam int FLD_ROW1_A   = 3;
    localparam int FLD_ROW1_B   = 4;
    localparam int FLD_ROW1_OFS = 5;
    localparam int NUM_FIELDS   = 6;

    typedef logic [NUM_FIELDS-1:0][31:0] tex_matrix_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [31:0]             s_time_ms;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [31:0]      m_row0_a;
    logic signed [31:0]      m_row0_b;
    logic signed [31:0]      m_row0_offset;
    logic signed [31:0]      m_row1_a;
    logic signed [31:0]      m_row1_b;
    logic signed [31:0]      m_row1_offset;

    rotating_texture_matrix_generator_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row0_a      (m_row0_a),
        .m_row0_b      (m_row0_b),
        .m_row0_offset (m_row0_offset),
        .m_row1_a      (m_row1_a),
        .m_row1_b      (m_row1_b),
        .m_row1_offset (m_row1_offset)
    );

    // Predictor copy of registers and state
    logic signed [31:0] rate_r;
    logic signed [31:0] scale_u_r;
    logic signed [31:0] scale_v_r;
    logic signed [31:0] pivot_u_r;
    logic signed [31:0] pivot_v_r;
    logic [31:0]        last_time;
    logic [31:0]        phase_acc;
    int                 sine_mag [0:SINE_QSIZE];

    tex_matrix_t matrix_fifo [$];
    tex_matrix_t got_matrix;
    tex_matrix_t want_matrix;
    string       field_label [0:NUM_FIELDS-1] =
        '{"row0_a", "row0_b", "row0_offset", "row1_a", "row1_b", "row1_offset"};

    int mismatches;
    int items_sent;
    int matrices_checked;
    int cfg_writes;
    int stall_cycles;
    bit offering;
    bit tx_steady;
    bit rx_steady;
    bit hold_request;
    bit item_bad;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Quarter-wave magnitudes: Taylor series in Q2.30, rounded to Q1.15
    function automatic void fill_sine_table();
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        for (int i = 0; i <= SINE_QSIZE; i++) begin
            ang    = (HALF_PI_Q30 * u64_t'(i)) / u64_t'(SINE_QSIZE);
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * ang_sq) >> 30) / u64_t'((2 * k) * (2 * k + 1));
                acc  = ((k % 2) == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            sine_mag[i] = int'((u64_t'(acc) + 64'd16384) >> 15);
        end
    endfunction

    // Sine of a phase word, Q1.15 with 32768 meaning 1.0
    function automatic longint table_sine(logic [31:0] p);
        logic [31:0] r;
        logic [1:0]  quad;
        int          idx;
        longint      v;
        r    = p + ROM_ROUND;
        quad = r[31:30];
        idx  = int'((r >> (30 - SINE_TABLE_BITS)) & (SINE_QSIZE - 1));
        v    = quad[0] ? sine_mag[SINE_QSIZE - idx] : sine_mag[idx];
        return quad[1] ? -v : v;
    endfunction

    // floor(v / 2^n + 1/2)
    function automatic longint round_half_up(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Advance time and phase, then form the six matrix entries
    function automatic tex_matrix_t predict_matrix(logic [31:0] now);
        logic [31:0] delta;
        longint      s;
        longint      c;
        longint      su;
        longint      sv;
        longint      pu;
        longint      pv;
        longint      t0;
        longint      t1;
        tex_matrix_t m;
        delta     = now - last_time;
        last_time = now;
        phase_acc = phase_acc + rate_r * delta;
        s  = table_sine(phase_acc);
        c  = table_sine(phase_acc + QUARTER_TURN);
        su = longint'(scale_u_r);
        sv = longint'(scale_v_r);
        pu = longint'(pivot_u_r);
        pv = longint'(pivot_v_r);
        t0 = clamp32(round_half_up(c * pu - s * pv - pu * 32768, 15));
        t1 = clamp32(round_half_up(s * pu + c * pv - pv * 32768, 15));
        m[FLD_ROW0_A]   = 32'(clamp32(round_half_up(su * c, 15)));
        m[FLD_ROW0_B]   = 32'(clamp32(round_half_up(-(su * s), 15)));
        m[FLD_ROW0_OFS] = 32'(clamp32(round_half_up(-(su * t0), 16)));
        m[FLD_ROW1_A]   = 32'(clamp32(round_half_up(sv * s, 15)));
        m[FLD_ROW1_B]   = 32'(clamp32(round_half_up(sv * c, 15)));
        m[FLD_ROW1_OFS] = 32'(clamp32(round_half_up(-(sv * t1), 16)));
        return m;
    endfunction

    // Random register value: extremes or unit scale, full range, or a moderate signed magnitude
    function automatic logic [31:0] pick_word(int moderate_bits);
        logic [31:0] mag;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '0;
                    3: return WORD_ONES;
                    default: return SCALE_RESET;
                endcase
            end
            1: return $urandom;
            default: begin
                mag = $urandom_range(0, 1 << moderate_bits);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    // Mostly steady frame time progression, some jumps, backward steps and repeats
    function automatic logic [31:0] next_frame_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return last_time + $urandom_range(0, 40);
        end else if (pick < 85) begin
            return $urandom;
        end else if (pick < 95) begin
            return last_time - $urandom_range(1, 1000);
        end
        return last_time;
    endfunction

    // One register write; the predictor copy follows it
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_PHASE_RATE: rate_r    = data;
            REG_SCALE_U:    scale_u_r = data;
            REG_SCALE_V:    scale_v_r = data;
            REG_PIVOT_U:    pivot_u_r = data;
            REG_PIVOT_V:    pivot_v_r = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Stop offering and wait until the block has delivered everything
    task automatic drain_results();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge aclk);
        while (matrix_fifo.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] rate, input logic [31:0] su,
                              input logic [31:0] sv, input logic [31:0] pu,
                              input logic [31:0] pv);
        drain_results();
        cfg_write(REG_PHASE_RATE, rate);
        cfg_write(REG_SCALE_U, su);
        cfg_write(REG_SCALE_V, sv);
        cfg_write(REG_PIVOT_U, pu);
        cfg_write(REG_PIVOT_V, pv);
    endtask

    // Offer one time stamp, hold it until the transaction completes, then predict
    task automatic send_time(input logic [31:0] now);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 30);
        end
        if (gap > 0) begin
            if (offering) begin
                s_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_time_ms <= now;
        offering = 1'b1;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        matrix_fifo.push_back(predict_matrix(now));
        items_sent++;
    endtask

    // Reset defaults: unit scale, zero rate, time extremes
    task automatic test_reset_defaults();
        send_time(32'd0);
        send_time(WORD_ONES);
        send_time(WORD_MIN);
        send_time(32'd1);
    endtask

    // Walk the quadrants, a negative half-turn rate with time going backwards,
    // and a huge elapsed time
    task automatic test_phase_walk();
        set_config(QUARTER_TURN, SCALE_RESET, SCALE_RESET, 32'h0001_8000, 32'hFFFF_0000);
        repeat (4) send_time(last_time + 32'd1);
        set_config(WORD_MIN, SCALE_RESET, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000);
        send_time(last_time - 32'd1);
        send_time(last_time - 32'd3);
        set_config(WORD_MAX, SCALE_RESET, SCALE_RESET, 32'h0000_8000, 32'h0000_8000);
        send_time(last_time + WORD_MIN);
    endtask

    // Most negative scale with cosine exactly one, extreme pivots
    task automatic test_saturation();
        set_config(32'd0 - phase_acc, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
        send_time(last_time + 32'd1);
        send_time(last_time);
        set_config(EIGHTH_TURN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
        repeat (3) send_time(last_time + 32'd1);
    endtask

    // Writes above the last register are dropped
    task automatic test_unused_index();
        drain_results();
        for (int k = int'(REG_PIVOT_V) + 1; k < (1 << CFG_INDEX_W); k++) begin
            cfg_write(CFG_INDEX_W'(k), $urandom);
        end
        send_time(last_time + 32'd5);
        send_time(last_time + 32'd7);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        set_config(pick_word(22), pick_word(19), pick_word(19), pick_word(20), pick_word(20));
        tx_steady    = 1'b1;
        hold_request = 1'b1;
        repeat (12) send_time(last_time + $urandom_range(1, 40));
        tx_steady = 1'b0;
        drain_results();
    endtask

    // Random settings, each followed by a run of random frame times
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(pick_word(22), pick_word(19), pick_word(19), pick_word(20), pick_word(20));
            tx_steady = (p == 2);
            rx_steady = (p == 2);
            repeat (PHASE_ITEMS) send_time(next_frame_time());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result receiver: random stalls, a steady stretch, and one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Result checker: each transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_matrix[FLD_ROW0_A]   = m_row0_a;
            got_matrix[FLD_ROW0_B]   = m_row0_b;
            got_matrix[FLD_ROW0_OFS] = m_row0_offset;
            got_matrix[FLD_ROW1_A]   = m_row1_a;
            got_matrix[FLD_ROW1_B]   = m_row1_b;
            got_matrix[FLD_ROW1_OFS] = m_row1_offset;
            if (matrix_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with no pending prediction", $realtime);
                end
            end else begin
                want_matrix = matrix_fifo.pop_front();
                matrices_checked++;
                item_bad = 1'b0;
                for (int f = 0; f < NUM_FIELDS; f++) begin
                    if (got_matrix[f] !== want_matrix[f]) begin
                        if (!item_bad) begin
                            mismatches++;
                        end
                        item_bad = 1'b1;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: matrix %0d %s expected %h actual %h", $realtime,
                                     matrices_checked, field_label[f], want_matrix[f],
                                     got_matrix[f]);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any transaction or register write
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_time_ms    = '0;
        offering     = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        mismatches       = 0;
        items_sent       = 0;
        matrices_checked = 0;
        cfg_writes       = 0;
        stall_cycles     = 0;
        fill_sine_table();
        rate_r    = '0;
        scale_u_r = SCALE_RESET;
        scale_v_r = SCALE_RESET;
        pivot_u_r = '0;
        pivot_v_r = '0;
        last_time = '0;
        phase_acc = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_phase_walk();
        test_saturation();
        test_unused_index();
        test_backpressure();
        test_random_traffic();
        drain_results();

        $display("summary: %0d time stamps, %0d matrices checked, %0d register writes",
                 items_sent, matrices_checked, cfg_writes);
        $display("covered: quadrant walk, saturation, unused indexes, backward time, hold-off");
        if (mismatches == 0 && matrix_fifo.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
